FILE: src/tofpc_pkg.sv
`timescale 1ns / 1ps
package tofpc_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_COL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_COL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_ROW = 2'd3;

  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [13:0] PRINCIPAL_COL_RST = 14'd2560;
  localparam logic [13:0] PRINCIPAL_ROW_RST = 14'd1920;
  localparam logic [19:0] INV_FOCAL_COL_RST = 20'd5243;
  localparam logic [19:0] INV_FOCAL_ROW_RST = 20'd5243;

  // largest depth the datapath can produce
  localparam logic [13:0] POINT_Z_MAX = 14'd9997;

  typedef struct packed {
    logic [11:0] phase_code;
    logic [9:0]  pixel_col;
    logic [9:0]  pixel_row;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [13:0]        point_z;
  } point_t;

endpackage

FILE: src/tof_phase_to_point_cloud.sv
`timescale 1ns / 1ps
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+--------------------------------
// pixel    | in        | pixel_valid, pixel_stall | phase_code, pixel_col, pixel_row
// point    | out       | point_valid, point_stall | point_x, point_y, point_z
// cfg      | in        | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// one pixel request enters per cycle while the output is not stalled
// the pipeline depth is set by the square root (27 steps) and the reciprocal (17 steps), one
// bit per stage, plus eight multiply and setup stages
// rst is synchronous; it clears the valid bits and loads the default calibration
// a stalled output freezes the whole pipeline, so pixel_stall follows point_stall
// while a result is held; no request is lost or repeated
module tof_phase_to_point_cloud (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pixel_valid,
  output logic                                  pixel_stall,
  input  tofpc_pkg::pixel_t                     pixel,
  output logic                                  point_valid,
  input  logic                                  point_stall,
  output tofpc_pkg::point_t                     point,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tofpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tofpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tofpc_pkg::*;

  localparam int unsigned SQ_N  = 27;   // root bits of a 54-bit radicand
  localparam int unsigned DIV_N = 17;   // quotient bits of the Q1.16 factor

  // side data that rides along the root and reciprocal stages
  typedef struct packed {
    logic [21:0] pm;     // phase_code * 625
    logic [13:0] adc;    // |dc|
    logic [13:0] adr;    // |dr|
    logic        neg_c;
    logic        neg_r;
  } side_t;

  // calibration registers
  logic [13:0] principal_col;
  logic [13:0] principal_row;
  logic [19:0] inv_focal_col;
  logic [19:0] inv_focal_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      principal_col <= PRINCIPAL_COL_RST;
      principal_row <= PRINCIPAL_ROW_RST;
      inv_focal_col <= INV_FOCAL_COL_RST;
      inv_focal_row <= INV_FOCAL_ROW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRINCIPAL_COL: principal_col <= cfg_data[13:0];
        REG_PRINCIPAL_ROW: principal_row <= cfg_data[13:0];
        REG_INV_FOCAL_COL: inv_focal_col <= cfg_data;
        REG_INV_FOCAL_ROW: inv_focal_row <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless the output register holds a stalled result
  logic en;
  assign en          = !(point_valid && point_stall);
  assign pixel_stall = !en;

  // stage a: offsets from the principal point, split into magnitude and sign
  logic signed [14:0] dc, dr;
  assign dc = $signed({1'b0, principal_col}) - $signed({1'b0, pixel.pixel_col, 4'b0000});
  assign dr = $signed({1'b0, principal_row}) - $signed({1'b0, pixel.pixel_row, 4'b0000});

  logic        a_vld;
  logic [11:0] a_phase;
  logic [13:0] a_adc, a_adr;
  logic        a_neg_c, a_neg_r;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= pixel_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_phase <= pixel.phase_code;
      a_neg_c <= dc[14];
      a_neg_r <= dr[14];
      a_adc   <= dc[14] ? 14'(-dc) : 14'(dc);
      a_adr   <= dr[14] ? 14'(-dr) : 14'(dr);
    end
  end

  // stage b: normalized offsets u, v in Q.16
  logic [33:0] prod_u, prod_v;
  assign prod_u = 34'(a_adc) * 34'(inv_focal_col);
  assign prod_v = 34'(a_adr) * 34'(inv_focal_row);

  logic        b_vld;
  logic [25:0] b_u, b_v;
  side_t       b_side;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_u          <= prod_u[33:8];
      b_v          <= prod_v[33:8];
      b_side.pm    <= 22'(a_phase) * 22'd625;
      b_side.adc   <= a_adc;
      b_side.adr   <= a_adr;
      b_side.neg_c <= a_neg_c;
      b_side.neg_r <= a_neg_r;
    end
  end

  // stage c: squares
  logic        c_vld;
  logic [51:0] c_uu, c_vv;
  side_t       c_side;

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_uu   <= 52'(b_u) * 52'(b_u);
      c_vv   <= 52'(b_v) * 52'(b_v);
      c_side <= b_side;
    end
  end

  // stage d: radicand 1 + u^2 + v^2 in Q.32
  logic        d_vld;
  logic [53:0] d_s;
  side_t       d_side;

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else if (en) d_vld <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s    <= (54'(1) << 32) + 54'(c_uu) + 54'(c_vv);
      d_side <= c_side;
    end
  end

  // integer square root, one root bit per stage
  logic        sq_vld  [SQ_N];
  logic [53:0] sq_rem  [SQ_N];
  logic [53:0] sq_res  [SQ_N];
  side_t       sq_side [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam logic [53:0] BIT = 54'(1) << (2 * (SQ_N - 1 - j));
    logic        vld_in;
    logic [53:0] rem_in, res_in, trial;
    side_t       side_in;

    if (j == 0) begin : g_first
      assign vld_in  = d_vld;
      assign rem_in  = d_s;
      assign res_in  = '0;
      assign side_in = d_side;
    end else begin : g_next
      assign vld_in  = sq_vld[j-1];
      assign rem_in  = sq_rem[j-1];
      assign res_in  = sq_res[j-1];
      assign side_in = sq_side[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[j] <= 1'b0;
      else if (en) sq_vld[j] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[j] <= side_in;
        if (rem_in >= trial) begin
          sq_rem[j] <= rem_in - trial;
          sq_res[j] <= (res_in >> 1) + BIT;
        end else begin
          sq_rem[j] <= rem_in;
          sq_res[j] <= res_in >> 1;
        end
      end
    end
  end

  // reciprocal 2^32 / root, restoring division, one quotient bit per stage
  logic        dv_vld  [DIV_N];
  logic [32:0] dv_rem  [DIV_N];
  logic [26:0] dv_den  [DIV_N];
  logic [16:0] dv_quo  [DIV_N];
  side_t       dv_side [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    localparam int unsigned SH = DIV_N - 1 - i;
    logic        vld_in;
    logic [32:0] rem_in;
    logic [26:0] den_in;
    logic [16:0] quo_in;
    side_t       side_in;
    logic [43:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign vld_in  = sq_vld[SQ_N-1];
      assign rem_in  = 33'(1) << 32;
      assign den_in  = sq_res[SQ_N-1][26:0];
      assign quo_in  = '0;
      assign side_in = sq_side[SQ_N-1];
    end else begin : g_next
      assign vld_in  = dv_vld[i-1];
      assign rem_in  = dv_rem[i-1];
      assign den_in  = dv_den[i-1];
      assign quo_in  = dv_quo[i-1];
      assign side_in = dv_side[i-1];
    end

    assign trial = 44'(den_in) << SH;
    assign take  = 44'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (rst) dv_vld[i] <= 1'b0;
      else if (en) dv_vld[i] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[i]  <= den_in;
        dv_side[i] <= side_in;
        dv_quo[i]  <= {quo_in[15:0], take};
        dv_rem[i]  <= take ? 33'(44'(rem_in) - trial) : rem_in;
      end
    end
  end

  // stage z: depth = phase * 625 * factor / 2^24
  logic [38:0] zprod;
  assign zprod = 39'(dv_side[DIV_N-1].pm) * 39'(dv_quo[DIV_N-1]);

  logic        z_vld;
  logic [13:0] z_z;
  side_t       z_side;

  always_ff @(posedge clk) begin
    if (rst) z_vld <= 1'b0;
    else if (en) z_vld <= dv_vld[DIV_N-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_z    <= zprod[37:24];
      z_side <= dv_side[DIV_N-1];
    end
  end

  // stage p1: |d| * z
  logic        p1_vld;
  logic [27:0] p1_mc, p1_mr;
  logic [13:0] p1_z;
  logic        p1_neg_c, p1_neg_r;

  always_ff @(posedge clk) begin
    if (rst) p1_vld <= 1'b0;
    else if (en) p1_vld <= z_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_mc    <= 28'(z_side.adc) * 28'(z_z);
      p1_mr    <= 28'(z_side.adr) * 28'(z_z);
      p1_z     <= z_z;
      p1_neg_c <= z_side.neg_c;
      p1_neg_r <= z_side.neg_r;
    end
  end

  // stage p2: times the focal reciprocal
  logic        p2_vld;
  logic [47:0] p2_magc, p2_magr;
  logic [13:0] p2_z;
  logic        p2_neg_c, p2_neg_r;

  always_ff @(posedge clk) begin
    if (rst) p2_vld <= 1'b0;
    else if (en) p2_vld <= p1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_magc  <= 48'(p1_mc) * 48'(inv_focal_col);
      p2_magr  <= 48'(p1_mr) * 48'(inv_focal_row);
      p2_z     <= p1_z;
      p2_neg_c <= p1_neg_c;
      p2_neg_r <= p1_neg_r;
    end
  end

  // floor of signed magnitude / 2^24, saturated to 16 bits
  function automatic logic [15:0] project(input logic [47:0] mag, input logic neg);
    logic [23:0] fl;
    logic [24:0] cl;
    logic [15:0] ret;
    fl = mag[47:24];
    cl = 25'((49'(mag) + 49'h0FFFFFF) >> 24);
    if (!neg) ret = (fl > 24'd32767) ? 16'h7FFF : fl[15:0];
    else      ret = (cl > 25'd32768) ? 16'h8000 : 16'(25'd0 - cl);
    return ret;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) point_valid <= 1'b0;
    else if (en) point_valid <= p2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point.point_x <= $signed(project(p2_magc, p2_neg_c));
      point.point_y <= $signed(project(p2_magr, p2_neg_r));
      point.point_z <= p2_z;
    end
  end

endmodule

FILE: src/tofpc_checker.sv
`timescale 1ns / 1ps
module tofpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              pixel_stall,
  input logic              point_valid,
  input logic              point_stall,
  input tofpc_pkg::point_t point
);
  import tofpc_pkg::*;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !point_valid)
    else $error("result valid right after reset");

  // input backpressure only comes from a held output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (point_valid && point_stall))
    else $error("pixel stalled without a held result");

  // depth stays in range
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point.point_z <= POINT_Z_MAX))
    else $error("depth out of range");

  // zero depth projects to the origin
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point.point_z == '0) |-> (point.point_x == '0 && point.point_y == '0))
    else $error("nonzero coordinate at zero depth");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_stall) |=> (point_valid && $stable(point)))
    else $error("stalled result changed");

endmodule

bind tof_phase_to_point_cloud tofpc_checker u_tofpc_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_stall (pixel_stall),
  .point_valid (point_valid),
  .point_stall (point_stall),
  .point       (point)
);

FILE: bench/tof_phase_to_point_cloud_tb.sv
`timescale 1ns / 1ps
module tof_phase_to_point_cloud_tb;
  import tofpc_pkg::*;

  // settling time after the last result; longer than the pipeline depth
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic point_valid;
  logic point_stall = 1'b0;
  point_t point;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tof_phase_to_point_cloud dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the calibration registers
  longint cal_pcol, cal_prow, cal_ifcol, cal_ifrow;

  pixel_t pixel_q[$];      // requests waiting to be driven
  point_t expected_q[$];   // predicted points, oldest first
  int errors = 0;
  bit calm = 1'b0;         // when set, neither side idles
  bit pix_taken, pt_taken;
  int pix_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(d * z * inv / 2^24), clamped to signed 16 bits
  function automatic logic [15:0] back_project(longint d, longint unsigned z,
                                               longint unsigned inv);
    longint unsigned mag;
    longint q;
    mag = longint'(d < 0 ? -d : d) * z * inv;
    if (d >= 0) q = longint'(mag >> 24);
    else q = -longint'((mag + 64'hFFFFFF) >> 24);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic point_t pixel_to_point(pixel_t p);
    longint dc, dr;
    longint unsigned u, v, s, r, factor, z;
    point_t res;
    dc = cal_pcol - 16 * longint'({54'd0, p.pixel_col});
    dr = cal_prow - 16 * longint'({54'd0, p.pixel_row});
    u = (longint'(dc < 0 ? -dc : dc) * cal_ifcol) >> 8;
    v = (longint'(dr < 0 ? -dr : dr) * cal_ifrow) >> 8;
    s = (64'd1 << 32) + u * u + v * v;
    r = int_sqrt(s);
    factor = (64'd1 << 32) / r;
    z = (longint'({52'd0, p.phase_code}) * 625 * factor) >> 24;
    res.point_x = back_project(dc, z, cal_ifcol);
    res.point_y = back_project(dr, z, cal_ifrow);
    res.point_z = z[13:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int k;
    k = int'($urandom_range(0, 99));
    if (calm || k < 55) return 0;
    if (k < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    pix_taken = pixel_valid && !pixel_stall && !rst;
    pt_taken = point_valid && !point_stall && !rst;
    if (pix_taken) expected_q.push_back(pixel_to_point(pixel));
    if (pt_taken) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time,
                 point.point_x, point.point_y, point.point_z);
        errors++;
      end else begin
        point_t want;
        want = expected_q.pop_front();
        if (point.point_x !== want.point_x) begin
          $display("%0t: point_x expected %0d actual %0d", $time,
                   want.point_x, point.point_x);
          errors++;
        end
        if (point.point_y !== want.point_y) begin
          $display("%0t: point_y expected %0d actual %0d", $time,
                   want.point_y, point.point_y);
          errors++;
        end
        if (point.point_z !== want.point_z) begin
          $display("%0t: point_z expected %0d actual %0d", $time,
                   want.point_z, point.point_z);
          errors++;
        end
      end
    end
    // watchdog on cycles with no handshake of any kind
    if (pix_taken || pt_taken || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tof_phase_to_point_cloud_tb failed");
      $finish;
    end
  end

  // pixel driver: valid holds until the request is taken
  always @(negedge clk) begin
    if (!rst && (!pixel_valid || pix_taken)) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pixel_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        pixel <= pixel_q.pop_front();
        pixel_valid <= 1'b1;
        pix_gap = pick_gap();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // point receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      point_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      point_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRINCIPAL_COL: cal_pcol = longint'({50'd0, val[13:0]});
      REG_PRINCIPAL_ROW: cal_prow = longint'({50'd0, val[13:0]});
      REG_INV_FOCAL_COL: cal_ifcol = longint'({44'd0, val});
      REG_INV_FOCAL_ROW: cal_ifrow = longint'({44'd0, val});
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every request has come back, then let the pipeline settle
  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() != 0 || pixel_valid || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_pixel(int ph, int col, int row);
    pixel_t p;
    p.phase_code = 12'(ph);
    p.pixel_col = 10'(col);
    p.pixel_row = 10'(row);
    pixel_q.push_back(p);
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      // a share of pixels lands near the principal point
      if ($urandom_range(0, 3) == 0)
        add_pixel(int'($urandom_range(0, 4095)),
                  int'(cal_pcol >> 4) + int'($urandom_range(0, 8)) - 4,
                  int'(cal_prow >> 4) + int'($urandom_range(0, 8)) - 4);
      else
        add_pixel(int'($urandom_range(0, 4095)), int'($urandom_range(0, 1023)),
                  int'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    cal_pcol = longint'({50'd0, PRINCIPAL_COL_RST});
    cal_prow = longint'({50'd0, PRINCIPAL_ROW_RST});
    cal_ifcol = longint'({44'd0, INV_FOCAL_COL_RST});
    cal_ifrow = longint'({44'd0, INV_FOCAL_ROW_RST});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, the principal point itself, beyond-frame corners
    add_pixel(0, 0, 0);
    add_pixel(4095, 0, 0);
    add_pixel(4095, 1023, 1023);
    add_pixel(4095, 160, 120);
    add_pixel(1, 160, 120);
    add_pixel(4095, 1023, 0);
    add_pixel(4095, 0, 1023);
    add_pixel(2730, 511, 512);
    add_pixel(1365, 341, 682);
    add_random(200);
    drain();

    // extreme calibrations: zero focal reciprocal, largest reciprocal, edges
    write_reg(REG_INV_FOCAL_COL, '0);
    write_reg(REG_INV_FOCAL_ROW, 20'hFFFFF);
    write_reg(REG_PRINCIPAL_COL, 20'h3FFF);
    write_reg(REG_PRINCIPAL_ROW, '0);
    add_pixel(4095, 0, 0);
    add_pixel(4095, 1023, 1023);
    add_pixel(1, 0, 1023);
    add_random(200);
    drain();

    write_reg(REG_INV_FOCAL_COL, 20'hFFFFF);
    write_reg(REG_INV_FOCAL_ROW, '0);
    write_reg(REG_PRINCIPAL_COL, '0);
    write_reg(REG_PRINCIPAL_ROW, 20'hFFFFF);  // upper bits dropped
    calm = 1'b1;
    add_pixel(4095, 1023, 0);
    add_random(200);
    drain();
    calm = 1'b0;

    // random calibrations, mostly realistic focal lengths
    repeat (6) begin
      write_reg(REG_PRINCIPAL_COL, 20'($urandom_range(0, 20'hFFFFF)));
      write_reg(REG_PRINCIPAL_ROW, 20'($urandom_range(0, 20'hFFFFF)));
      write_reg(REG_INV_FOCAL_COL, ($urandom_range(0, 3) == 0) ?
                20'($urandom_range(0, 20'hFFFFF)) : 20'($urandom_range(1000, 20000)));
      write_reg(REG_INV_FOCAL_ROW, ($urandom_range(0, 3) == 0) ?
                20'($urandom_range(0, 20'hFFFFF)) : 20'($urandom_range(1000, 20000)));
      calm = ($urandom_range(0, 3) == 0);
      add_random(215);
      drain();
    end

    if (errors == 0) $display("tof_phase_to_point_cloud_tb passed");
    else $display("tof_phase_to_point_cloud_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/tofpc_pkg.sv
src/tof_phase_to_point_cloud.sv
src/tofpc_checker.sv
bench/tof_phase_to_point_cloud_tb.sv
